@@ rtl/core/image_source_multitap_reverb_core_macros.svh @@
// Assertion macros for the checker file.
// Depends on nothing; included by name where assertions are written.
`ifndef IMAGE_SOURCE_MULTITAP_REVERB_CORE_MACROS_SVH
`define IMAGE_SOURCE_MULTITAP_REVERB_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define ISRV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isrv assertion failed");

// next-cycle implication, off during reset
`define ISRV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isrv assertion failed");

`endif

@@ rtl/core/isrv_pkg.sv @@
// Shared constants, register codes and controller/datapath structs for the reverb core.
// No dependencies.
package isrv_pkg;

    localparam int RING_DEPTH_DEF = 4096;
    localparam int MAX_TAPS_DEF   = 16;
    localparam int MAX_ORDER_DEF  = 15;

    localparam int DIVD_W = 30;
    localparam int DIVS_W = 20;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 20;

    localparam logic [15:0] GAIN_NINE_TENTHS = 16'd58982;
    localparam logic [16:0] GAIN_UNITY       = 17'd65536;
    localparam logic [DIVS_W-1:0] MS_PER_S   = DIVS_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ABSORB = 8'd3;

    localparam logic [9:0]  HOLD_RST   = 10'd85;
    localparam logic [17:0] RATE_RST   = 18'd48000;
    localparam logic [19:0] SPEED_RST  = 20'd343000;
    localparam logic [15:0] ABSORB_RST = 16'd52429;

    localparam logic [1:0] DIV_SIZE = 2'd0;
    localparam logic [1:0] DIV_DMS  = 2'd1;
    localparam logic [1:0] DIV_DD   = 2'd2;
    localparam logic [1:0] DIV_MOD  = 2'd3;

    typedef struct packed {
        logic       take;
        logic       clr_step;
        logic       div_start;
        logic [1:0] div_sel;
        logic       lat_size;
        logic       ring_wr;
        logic       tap_next;
        logic       lat_pos;
        logic       ram_rd;
        logic       gain_step;
        logic       mul;
        logic       acc;
        logic       fin1;
        logic       fin2;
        logic       out_load;
    } isrv_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic tap_active;
        logic dms_skip;
        logic tap_last;
        logic gain_done;
        logic out_busy;
    } isrv_stat_t;

endpackage

@@ rtl/core/isrv_if.sv @@
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on isrv_pkg.
interface isrv_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] in_sample;
    logic [3:0]  tap_index;
    logic        tap_enable;
    logic [19:0] tap_distance;
    logic [3:0]  tap_order;
    modport source (output valid, action, in_sample, tap_index, tap_enable, tap_distance,
                    tap_order, input ready);
    modport sink (input valid, action, in_sample, tap_index, tap_enable, tap_distance,
                  tap_order, output ready);
endinterface

interface isrv_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_sample;
    modport source (output valid, out_sample, input ready);
    modport sink (input valid, out_sample, output ready);
endinterface

interface isrv_cfg_if import isrv_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/image_source_multitap_reverb_core.sv @@
// Top level of the multitap image-source reverb: controller plus datapath.
// Depends on isrv_pkg, isrv_if, isrv_ctrl, isrv_dp.
//
// Channels: items (sink) carries audio samples (action 0) and tap table writes
// (action 1); results (source) carries one out_sample per audio item; cfg takes
// register writes (hold time, sample rate, speed of sound, absorption) at any
// time, always ready.
// A tap write is taken without leaving the idle state, so the block is ready again right after.
// An audio item is taken, then the ring size is computed and the sample is
// written; then per tap: a disabled tap is skipped, a tap whose delay exceeds
// the hold time is skipped after the delay division in ms, and otherwise the
// delay in samples, its wrap, the ring read, one gain step per order, the
// multiply and the accumulate follow; the 1-bit-per-cycle divider does the
// delay in ms and the wrap. The next item is taken in the cycle after the result loads.
// The result sits in an output register; the next item is accepted while it
// waits, and only the final load stalls until the receiver takes it.
// After reset the delay ring is cleared one entry a cycle, and no item is
// accepted during the clearing pass.
module image_source_multitap_reverb_core import isrv_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int MAX_TAPS   = MAX_TAPS_DEF,
    parameter int MAX_ORDER  = MAX_ORDER_DEF
) (
    input logic       clk,
    input logic       rst_n,
    isrv_in_if.sink   items,
    isrv_out_if.source results,
    isrv_cfg_if.sink  cfg
);
    isrv_cmd_t  cmd;
    isrv_stat_t st;

    assign cfg.ready = 1'b1;

    isrv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .action   (items.action),
        .in_ready (items.ready),
        .cmd      (cmd),
        .st       (st)
    );

    isrv_dp #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_TAPS   (MAX_TAPS),
        .MAX_ORDER  (MAX_ORDER)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .action       (items.action),
        .in_sample    (items.in_sample),
        .tap_index    (items.tap_index),
        .tap_enable   (items.tap_enable),
        .tap_distance (items.tap_distance),
        .tap_order    (items.tap_order),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .out_sample   (results.out_sample)
    );
endmodule

@@ rtl/core/isrv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isrv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/core/isrv_div.sv @@
// Restoring divider, one quotient bit per cycle, for the divisions by a register value.
// Depends on isrv_pkg.
module isrv_div import isrv_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic [DIVD_W-1:0] quo,
    output logic [DIVS_W-1:0] rem,
    output logic              done
);
    localparam int CNT_W = $clog2(DIVD_W);

    logic [DIVD_W-1:0] q_reg;
    logic [DIVS_W-1:0] r_reg;
    logic [DIVS_W-1:0] d_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;

    assign trial = {r_reg, q_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVD_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIVS_W])
            begin
                r_reg <= diff[DIVS_W-1:0];
                q_reg <= {q_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial[DIVS_W-1:0];
                q_reg <= {q_reg[DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign quo  = q_reg;
    assign rem  = r_reg;
    assign done = done_reg;
endmodule

@@ rtl/core/isrv_ctrl.sv @@
// Controller FSM: ring clearing pass, sample write, per-tap sequencing, output.
// Depends on isrv_pkg.
module isrv_ctrl import isrv_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       action,
    output logic       in_ready,
    output isrv_cmd_t  cmd,
    input  isrv_stat_t st
);
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SIZE  = 4'd2;
    localparam logic [3:0] S_WRITE = 4'd3;
    localparam logic [3:0] S_TAP   = 4'd4;
    localparam logic [3:0] S_DMS   = 4'd5;
    localparam logic [3:0] S_DD    = 4'd6;
    localparam logic [3:0] S_MOD   = 4'd7;
    localparam logic [3:0] S_READ  = 4'd8;
    localparam logic [3:0] S_GAIN  = 4'd9;
    localparam logic [3:0] S_MUL   = 4'd10;
    localparam logic [3:0] S_SUM   = 4'd11;
    localparam logic [3:0] S_FIN1  = 4'd12;
    localparam logic [3:0] S_FIN2  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cmd.take   = in_valid && in_ready;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !action)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SIZE;
                    state_next    = S_SIZE;
                end
            end
            S_SIZE:
            begin
                if (st.div_done)
                begin
                    cmd.lat_size = 1'b1;
                    state_next   = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.ring_wr = 1'b1;
                state_next  = S_TAP;
            end
            S_TAP:
            begin
                if (st.tap_active)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_DMS;
                    state_next    = S_DMS;
                end
                else if (st.tap_last)
                begin
                    state_next = S_FIN1;
                end
                else
                begin
                    cmd.tap_next = 1'b1;
                end
            end
            S_DMS:
            begin
                if (st.div_done)
                begin
                    if (!st.dms_skip)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_DD;
                        state_next    = S_DD;
                    end
                    else if (st.tap_last)
                    begin
                        state_next = S_FIN1;
                    end
                    else
                    begin
                        cmd.tap_next = 1'b1;
                        state_next   = S_TAP;
                    end
                end
            end
            S_DD:
            begin
                if (st.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_MOD;
                    state_next    = S_MOD;
                end
            end
            S_MOD:
            begin
                if (st.div_done)
                begin
                    cmd.lat_pos = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.ram_rd = 1'b1;
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                if (st.gain_done)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.gain_step = 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.acc = 1'b1;
                if (st.tap_last)
                begin
                    state_next = S_FIN1;
                end
                else
                begin
                    cmd.tap_next = 1'b1;
                    state_next   = S_TAP;
                end
            end
            S_FIN1:
            begin
                cmd.fin1   = 1'b1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.fin2   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

@@ rtl/core/isrv_dp.sv @@
// Datapath: registers, tap table, delay ring, divider, divide-by-1000, gain and accumulate.
// Depends on isrv_pkg, isrv_ram, isrv_div.
module isrv_dp import isrv_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int MAX_TAPS   = MAX_TAPS_DEF,
    parameter int MAX_ORDER  = MAX_ORDER_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  isrv_cmd_t            cmd,
    output isrv_stat_t           st,
    input  logic                 action,
    input  logic [15:0]          in_sample,
    input  logic [3:0]           tap_index,
    input  logic                 tap_enable,
    input  logic [19:0]          tap_distance,
    input  logic [3:0]           tap_order,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          out_sample
);
    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int S_W   = PTR_W + 1;
    localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int ACC_W = 34 + $clog2(MAX_TAPS + 1);
    localparam int LO_W  = 19;
    localparam int HI_W  = ACC_W - LO_W;
    localparam int PH_W  = HI_W + 17;
    localparam int YF_W  = PH_W + LO_W;
    localparam int Y_W   = YF_W - 32;
    localparam int KP_W  = 28;
    localparam int KQ_W  = 19;
    // ceil(2^38 / 1000); exact floor(x / 1000) for any x below 2^28
    localparam logic [28:0] INV_MS = 29'd274877907;

    logic [9:0]  hold_reg;
    logic [17:0] rate_reg;
    logic [19:0] speed_reg;
    logic [15:0] absorb_reg;

    logic [PTR_W-1:0] clr_addr_reg;
    logic [S_W-1:0]   size_reg;
    logic [S_W-1:0]   size_next;
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] last_reg;
    logic [PTR_W-1:0] last_next;
    logic [PTR_W-1:0] wp_next;
    logic [15:0]      dry_reg;

    logic             tap_en_reg  [MAX_TAPS];
    logic [19:0]      tap_len_reg [MAX_TAPS];
    logic [3:0]       tap_ord_reg [MAX_TAPS];
    logic [TAP_W-1:0] tcnt_reg;
    logic [TAP_W+3:0] idx_ext;

    logic [PTR_W-1:0] pos_reg;
    logic [S_W:0]     pos_wide;
    logic [16:0]      gain_reg;
    logic [32:0]      gain_prod;
    logic [3:0]       gcnt_reg;
    logic [3:0]       ord_sat;
    logic             neg_reg;

    logic signed [33:0]    term_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [PH_W-1:0]  phi_reg;
    logic signed [YF_W-1:0]  y_full;
    logic signed [Y_W-1:0]   y_reg;
    logic [15:0]             sat;
    logic [15:0]             out_reg;
    logic                    out_valid_reg;

    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic [DIVD_W-1:0] div_quo;
    logic [DIVS_W-1:0] div_rem;
    logic              div_done;

    logic              k_start;
    logic [KP_W-1:0]   k_prod_next;
    logic [KP_W-1:0]   k_prod_reg;
    logic [KP_W+28:0]  k_full;
    logic [KQ_W-1:0]   k_q_reg;
    logic              k_v1_reg;
    logic              k_done_reg;

    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [15:0]      ram_wdata;
    logic [15:0]      ram_rdata;

    assign idx_ext = {{TAP_W{1'b0}}, tap_index};

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= HOLD_RST;
            rate_reg   <= RATE_RST;
            speed_reg  <= SPEED_RST;
            absorb_reg <= ABSORB_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOLD:   hold_reg   <= cfg_data[9:0];
                CFG_RATE:   rate_reg   <= cfg_data[17:0];
                CFG_SPEED:  speed_reg  <= cfg_data[19:0];
                CFG_ABSORB: absorb_reg <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    // tap table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                tap_en_reg[i]  <= 1'b0;
                tap_len_reg[i] <= '0;
                tap_ord_reg[i] <= '0;
            end
        end
        else if (cmd.take && action && (int'(tap_index) < MAX_TAPS))
        begin
            tap_en_reg[idx_ext[TAP_W-1:0]]  <= tap_enable;
            tap_len_reg[idx_ext[TAP_W-1:0]] <= tap_distance;
            tap_ord_reg[idx_ext[TAP_W-1:0]] <= tap_order;
        end
    end

    // divide by 1000: the product is registered, then the reciprocal multiply in the next cycle
    assign k_start = cmd.div_start && ((cmd.div_sel == DIV_SIZE) || (cmd.div_sel == DIV_DD));

    always_comb
    begin
        if (cmd.div_sel == DIV_DD)
        begin
            k_prod_next = KP_W'({18'd0, div_quo[9:0]} * {10'd0, rate_reg});
        end
        else
        begin
            k_prod_next = KP_W'({18'd0, hold_reg} * {10'd0, rate_reg});
        end
    end

    assign k_full = {29'd0, k_prod_reg} * {28'd0, INV_MS};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_v1_reg   <= 1'b0;
            k_done_reg <= 1'b0;
        end
        else
        begin
            k_v1_reg   <= k_start;
            k_done_reg <= k_v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (k_start)
        begin
            k_prod_reg <= k_prod_next;
        end
        if (k_v1_reg)
        begin
            k_q_reg <= k_full[KP_W+28:38];
        end
    end

    // serial divider operand select
    always_comb
    begin
        div_dividend = '0;
        div_divisor  = MS_PER_S;
        case (cmd.div_sel)
            DIV_DMS:
            begin
                div_dividend = DIVD_W'(tap_len_reg[tcnt_reg]) * DIVD_W'(MS_PER_S);
                div_divisor  = speed_reg;
            end
            DIV_MOD:
            begin
                div_dividend = DIVD_W'(k_q_reg);
                div_divisor  = DIVS_W'(size_reg);
            end
            default:
            begin
                div_dividend = '0;
            end
        endcase
    end

    assign div_start = cmd.div_start && !k_start;

    isrv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quo      (div_quo),
        .rem      (div_rem),
        .done     (div_done)
    );

    // ring size, clamped to [1, RING_DEPTH]
    always_comb
    begin
        if (k_q_reg >= KQ_W'(RING_DEPTH))
        begin
            size_next = S_W'(RING_DEPTH);
        end
        else if (k_q_reg == '0)
        begin
            size_next = S_W'(1);
        end
        else
        begin
            size_next = S_W'(k_q_reg);
        end
    end

    always_comb
    begin
        last_next = ({1'b0, wp_reg} >= size_reg) ? '0 : wp_reg;
        wp_next   = ((S_W'(last_next) + 1'b1) >= size_reg) ? '0 : last_next + 1'b1;
    end

    // read position: last - d, wrapped; d already reduced below size
    always_comb
    begin
        if ({1'b0, last_reg} >= S_W'(div_rem))
        begin
            pos_wide = (S_W + 1)'(last_reg) - (S_W + 1)'(div_rem);
        end
        else
        begin
            pos_wide = (S_W + 1)'(last_reg) + (S_W + 1)'(size_reg) - (S_W + 1)'(div_rem);
        end
    end

    always_comb
    begin
        if (int'(tap_ord_reg[tcnt_reg]) > MAX_ORDER)
        begin
            ord_sat = 4'(MAX_ORDER);
        end
        else
        begin
            ord_sat = tap_ord_reg[tcnt_reg];
        end
    end

    assign gain_prod = gain_reg * absorb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            wp_reg       <= '0;
            tcnt_reg     <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.ring_wr)
            begin
                wp_reg   <= wp_next;
                tcnt_reg <= '0;
            end
            else if (cmd.tap_next)
            begin
                tcnt_reg <= tcnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            dry_reg <= in_sample;
        end
        if (cmd.lat_size)
        begin
            size_reg <= size_next;
        end
        if (cmd.ring_wr)
        begin
            last_reg <= last_next;
            acc_reg  <= ACC_W'($signed({dry_reg, 16'd0}));
        end
        if (cmd.lat_pos)
        begin
            pos_reg  <= pos_wide[PTR_W-1:0];
            gain_reg <= GAIN_UNITY;
            gcnt_reg <= ord_sat;
            neg_reg  <= ord_sat[0];
        end
        if (cmd.gain_step)
        begin
            gain_reg <= gain_prod[32:16];
            gcnt_reg <= gcnt_reg - 1'b1;
        end
        if (cmd.mul)
        begin
            term_reg <= $signed(ram_rdata) * $signed({1'b0, gain_reg});
        end
        if (cmd.acc)
        begin
            if (neg_reg)
            begin
                acc_reg <= acc_reg - ACC_W'(term_reg);
            end
            else
            begin
                acc_reg <= acc_reg + ACC_W'(term_reg);
            end
        end
        if (cmd.fin1)
        begin
            phi_reg <= $signed(acc_reg[ACC_W-1:LO_W]) * $signed({1'b0, GAIN_NINE_TENTHS});
        end
        if (cmd.fin2)
        begin
            y_reg <= y_full[YF_W-1:32];
        end
        if (cmd.out_load)
        begin
            out_reg <= sat;
        end
    end

    // floor((hi*2^19 + lo) * 58982 / 2^32), i.e. the sum times 0.9 over 2^16
    assign y_full = $signed({phi_reg, {LO_W{1'b0}}})
                  + $signed(YF_W'({1'b0, acc_reg[LO_W-1:0]} * {1'b0, GAIN_NINE_TENTHS}));

    always_comb
    begin
        if (!y_reg[Y_W-1] && (|y_reg[Y_W-2:15]))
        begin
            sat = 16'h7FFF;
        end
        else if (y_reg[Y_W-1] && !(&y_reg[Y_W-2:15]))
        begin
            sat = 16'h8000;
        end
        else
        begin
            sat = y_reg[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign ram_we    = cmd.clr_step || cmd.ring_wr;
    assign ram_waddr = cmd.clr_step ? clr_addr_reg : last_next;
    assign ram_wdata = cmd.clr_step ? 16'd0 : dry_reg;

    isrv_ram #(
        .WIDTH (16),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.ram_rd),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    assign st.clr_done   = (clr_addr_reg == PTR_W'(RING_DEPTH - 1));
    assign st.div_done   = div_done || k_done_reg;
    assign st.tap_active = tap_en_reg[tcnt_reg] && (speed_reg != '0);
    assign st.dms_skip   = (div_quo > DIVD_W'(hold_reg));
    assign st.tap_last   = (tcnt_reg == TAP_W'(MAX_TAPS - 1));
    assign st.gain_done  = (gcnt_reg == '0);
    assign st.out_busy   = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_sample = out_reg;
endmodule

@@ rtl/core/isrv_chk.sv @@
// Port-level checker for the reverb core, bound to the top level.
// Depends on image_source_multitap_reverb_core_macros.svh.
`include "image_source_multitap_reverb_core_macros.svh"

module isrv_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_sample,
    input logic        cfg_ready
);
    // stalled result holds
    `ISRV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_sample))
    // a result is only loaded while no item is being taken
    `ISRV_ASSERT_NOW(a_load_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))
    // clearing pass blocks input right after reset
    `ISRV_ASSERT_NEXT(a_clear_block, clk, rst_n, $rose(rst_n), !in_ready)
    // register port never stalls
    `ISRV_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)
endmodule

bind image_source_multitap_reverb_core isrv_chk u_isrv_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (items.valid),
    .in_ready   (items.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_sample (results.out_sample),
    .cfg_ready  (cfg.ready)
);
